### src/q4bq_pkg.sv
// Shared types and constants of the 4-bit block quantizer.
package q4bq_pkg;

	// Default number of values in one block
	localparam int BLOCK_VALUES_DEF = 32;

	// Reciprocal divider iterations: 24 mantissa bits plus one round bit
	localparam int DIV_STEPS = 25;

	// Running maximum floor: single precision bits of 1e-6
	localparam logic [31:0] MAX_FLOOR = 32'h358637BD;

	// Half precision infinity
	localparam logic [14:0] HALF_INF = 15'h7c00;

	// Input transaction payload
	typedef struct packed {
		logic [31:0] value_bits;
	} in_item_t;

	// Output transaction payload
	typedef struct packed {
		logic [15:0] scale_half;
		logic [7:0]  packed_byte;
		logic [3:0]  byte_index;
		logic        last_byte;
		logic        bad_input;
	} out_item_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load;
		logic       div_init;
		logic       div_step;
		logic       div_fin;
		logic       rd_en;
		logic       rd_hi;
		logic       rd_last;
		logic [3:0] byte_idx;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic byte_done;
	} status_t;

endpackage

### src/q4bq_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
interface q4bq_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### src/q4bq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module q4bq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### src/q4bq_ctrl.sv
// Controller: sequences block load, reciprocal division and byte packing.
module q4bq_ctrl import q4bq_pkg::*; #(
	parameter int BLOCK_VALUES = BLOCK_VALUES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            out_ready,
	output logic                            out_valid,
	input  status_t                         status,
	output cmd_t                            cmd,
	output logic [$clog2(BLOCK_VALUES)-1:0] wr_addr,
	output logic [$clog2(BLOCK_VALUES)-1:0] rd_addr
);
	localparam int AW     = $clog2(BLOCK_VALUES);
	localparam int HALF   = BLOCK_VALUES / 2;
	localparam int PAIR_W = (HALF > 1) ? $clog2(HALF) : 1;
	localparam int STEP_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		S_LOAD,
		S_DINIT,
		S_DSTEP,
		S_DFIN,
		S_PAIR_LO,
		S_PAIR_HI,
		S_WAIT
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       fill_q;
	logic [STEP_W-1:0]   step_q;
	logic [PAIR_W-1:0]   pair_q;
	logic                out_valid_q;
	logic                out_free;
	logic                pair_last;

	assign out_free  = !out_valid_q || out_ready;
	assign pair_last = (pair_q == PAIR_W'(HALF - 1));
	assign out_valid = out_valid_q;
	assign wr_addr   = fill_q;

	// Decode commands from state
	always_comb begin
		in_ready     = (state_q == S_LOAD);
		cmd          = '0;
		cmd.load     = in_ready && in_valid;
		cmd.div_init = (state_q == S_DINIT);
		cmd.div_step = (state_q == S_DSTEP);
		cmd.div_fin  = (state_q == S_DFIN);
		cmd.rd_en    = ((state_q == S_PAIR_LO) && out_free) || (state_q == S_PAIR_HI);
		cmd.rd_hi    = (state_q == S_PAIR_HI);
		cmd.rd_last  = pair_last;
		cmd.byte_idx = 4'(pair_q);
		if (state_q == S_PAIR_HI) begin
			rd_addr = AW'(pair_q) + AW'(HALF);
		end else begin
			rd_addr = AW'(pair_q);
		end
	end

	// Hold state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			fill_q      <= '0;
			step_q      <= '0;
			pair_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (status.byte_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (fill_q == AW'(BLOCK_VALUES - 1)) begin
							fill_q  <= '0;
							state_q <= S_DINIT;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				S_DINIT: begin
					step_q  <= '0;
					state_q <= S_DSTEP;
				end
				S_DSTEP: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_DFIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DFIN: begin
					pair_q  <= '0;
					state_q <= S_PAIR_LO;
				end
				S_PAIR_LO: begin
					if (out_free) begin
						state_q <= S_PAIR_HI;
					end
				end
				S_PAIR_HI: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (status.byte_done) begin
						if (pair_last) begin
							state_q <= S_LOAD;
						end else begin
							pair_q  <= pair_q + 1'b1;
							state_q <= S_PAIR_LO;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end
endmodule

### src/q4bq_dpath.sv
// Datapath: value store, running maximum, reciprocal divider, quantizer pipeline.
module q4bq_dpath import q4bq_pkg::*; #(
	parameter int BLOCK_VALUES = BLOCK_VALUES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmd_t                            cmd,
	input  logic [$clog2(BLOCK_VALUES)-1:0] wr_addr,
	input  logic [$clog2(BLOCK_VALUES)-1:0] rd_addr,
	input  logic [31:0]                     value_bits,
	output status_t                         status,
	output out_item_t                       result
);
	// Convert single to half: half-up rounding, overflow to infinity
	function automatic logic [15:0] to_half(input logic [31:0] b);
		logic signed [9:0] e;
		logic [23:0]       m;
		logic [4:0]        sh;
		logic [23:0]       shr;
		logic [10:0]       r;
		logic signed [9:0] e1;
		logic [15:0]       res;
		e  = $signed({2'b00, b[30:23]}) - 10'sd112;
		m  = {1'b1, b[22:0]};
		sh = '0;
		shr = '0;
		e1 = e + 10'sd1;
		if (e <= 10'sd0) begin
			if (e < -10'sd10) begin
				res = {b[31], 15'h0000};
			end else begin
				sh  = 5'(10'sd14 - e);
				shr = m >> sh;
				r   = shr[10:0] + {10'b0, m[sh - 5'd1]};
				res = {b[31], 15'(r)};
			end
		end else if (e >= 10'sd31) begin
			res = {b[31], HALF_INF};
		end else begin
			r = {1'b0, b[22:13]} + {10'b0, b[12]};
			if (r[10]) begin
				if (e1 >= 10'sd31) begin
					res = {b[31], HALF_INF};
				end else begin
					res = {b[31], e1[4:0], 10'b0};
				end
			end else begin
				res = {b[31], e[4:0], r[9:0]};
			end
		end
		return res;
	endfunction

	// Round product to single, then to integer half-to-even, clamp, bias by 8
	function automatic logic [3:0] quant_nibble(
		input logic [47:0]       p,
		input logic signed [9:0] esum,
		input logic              neg,
		input logic              is_nan,
		input logic              is_zero
	);
		logic [47:0]        nrm;
		logic signed [10:0] ep;
		logic [24:0]        r;
		logic [2:0]         sh;
		logic [29:0]        f;
		logic               up;
		logic [5:0]         mag;
		logic [3:0]         res;
		nrm = p[47] ? p : {p[46:0], 1'b0};
		ep  = {esum[9], esum} + {10'b0, p[47]};
		r   = {1'b0, nrm[47:24]} + 25'(nrm[23] && ((|nrm[22:0]) || nrm[24]));
		sh  = ep[2:0] + 3'd2;
		f   = {5'b0, r} << sh;
		up  = f[24] && ((|f[23:0]) || f[25]);
		mag = {1'b0, f[29:25]} + 6'(up);
		if (is_nan) begin
			res = 4'd0;
		end else if (is_zero || (ep < -11'sd2)) begin
			res = 4'd8;
		end else if (ep > 11'sd2) begin
			res = neg ? 4'd0 : 4'd15;
		end else if (neg) begin
			res = (mag >= 6'd8) ? 4'd0 : 4'(6'd8 - mag);
		end else begin
			res = (mag >= 6'd7) ? 4'd15 : 4'(6'd8 + mag);
		end
		return res;
	endfunction

	logic [31:0] rdata;

	// Block statistics
	logic [31:0] max_q;
	logic        nonfin_q;

	// Block scale and reciprocal
	logic [15:0] scale_half_q;
	logic        bad_q;
	logic [7:0]  d_exp_q;
	logic        d_frac_zero_q;
	logic        inv_zero_q;
	logic [23:0] div_m_q;
	logic [24:0] div_rem_q;
	logic [24:0] div_quo_q;
	logic [7:0]  inv_e_q;
	logic [23:0] inv_m_q;

	// Pipeline
	logic              valid_s1, hi_s1, last_s1;
	logic [3:0]        idx_s1;
	logic              valid_s2, hi_s2, last_s2;
	logic [3:0]        idx_s2;
	logic [47:0]       prod_s2;
	logic signed [9:0] esum_s2;
	logic              neg_s2, nan_s2, zero_s2;
	logic              valid_s3, hi_s3, last_s3;
	logic [3:0]        idx_s3;
	logic [3:0]        nib_s3;
	logic [3:0]        lo_q;

	logic [7:0]  max_e;
	logic [7:0]  d_e;
	logic        v_nan;
	logic        rem_ge;
	logic [24:0] rem_diff;
	logic [24:0] rsum;

	q4bq_ram #(
		.WIDTH(32),
		.DEPTH(BLOCK_VALUES)
	) u_store (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(wr_addr),
		.wdata(value_bits),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign max_e    = max_q[30:23];
	assign d_e      = (max_e == 8'hff) ? 8'hff : (max_e - 8'd3);
	assign v_nan    = (value_bits[30:23] == 8'hff) && (value_bits[22:0] != 23'd0);
	assign rem_ge   = (div_rem_q >= {1'b0, div_m_q});
	assign rem_diff = div_rem_q - {1'b0, div_m_q};
	assign rsum     = {1'b0, div_quo_q[24:1]}
		+ 25'(div_quo_q[0] && ((div_rem_q != 25'd0) || div_quo_q[1]));

	// Track maximum magnitude and non-finite inputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= MAX_FLOOR;
			nonfin_q <= 1'b0;
		end else if (cmd.div_init) begin
			max_q    <= MAX_FLOOR;
			nonfin_q <= 1'b0;
		end else if (cmd.load) begin
			if (value_bits[30:23] == 8'hff) begin
				nonfin_q <= 1'b1;
			end
			if (!v_nan && ({1'b0, value_bits[30:0]} > max_q)) begin
				max_q <= {1'b0, value_bits[30:0]};
			end
		end
	end

	// Scale, reciprocal divider and its rounding
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			scale_half_q  <= to_half({1'b0, d_e, max_q[22:0]});
			bad_q         <= nonfin_q;
			d_exp_q       <= d_e;
			d_frac_zero_q <= (max_q[22:0] == 23'd0);
			inv_zero_q    <= (max_e == 8'hff);
			div_m_q       <= {1'b1, max_q[22:0]};
			div_rem_q     <= 25'h1000000;
			div_quo_q     <= '0;
		end else if (cmd.div_step) begin
			div_rem_q <= {(rem_ge ? rem_diff[23:0] : div_rem_q[23:0]), 1'b0};
			div_quo_q <= {div_quo_q[23:0], rem_ge};
		end else if (cmd.div_fin) begin
			if (d_frac_zero_q || rsum[24]) begin
				inv_e_q <= 8'd254 - d_exp_q;
				inv_m_q <= 24'h800000;
			end else begin
				inv_e_q <= 8'd253 - d_exp_q;
				inv_m_q <= rsum[23:0];
			end
		end
	end

	// Advance pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Multiply, quantize and assemble bytes
	always_ff @(posedge clk) begin
		hi_s1   <= cmd.rd_hi;
		last_s1 <= cmd.rd_last;
		idx_s1  <= cmd.byte_idx;

		hi_s2   <= hi_s1;
		last_s2 <= last_s1;
		idx_s2  <= idx_s1;
		prod_s2 <= {1'b1, rdata[22:0]} * inv_m_q;
		esum_s2 <= $signed({2'b00, rdata[30:23]}) + $signed({2'b00, inv_e_q}) - 10'sd254;
		neg_s2  <= rdata[31];
		nan_s2  <= (rdata[30:23] == 8'hff);
		zero_s2 <= (rdata[30:23] == 8'h00) || inv_zero_q;

		hi_s3   <= hi_s2;
		last_s3 <= last_s2;
		idx_s3  <= idx_s2;
		nib_s3  <= quant_nibble(prod_s2, esum_s2, neg_s2, nan_s2, zero_s2);

		if (valid_s3 && !hi_s3) begin
			lo_q <= nib_s3;
		end
		if (valid_s3 && hi_s3) begin
			result.scale_half  <= scale_half_q;
			result.packed_byte <= {nib_s3, lo_q};
			result.byte_index  <= idx_s3;
			result.last_byte   <= last_s3;
			result.bad_input   <= bad_q;
		end
	end

	assign status.byte_done = valid_s3 && hi_s3;
endmodule

### src/q4_block_quantize_core.sv
// Top level: 4-bit block quantizer of single precision values.
// Load: one value per cycle in the load state, BLOCK_VALUES values per block into the value store.
// Reciprocal: init, 25 restoring divider steps, rounding, after the last value; no input is taken meanwhile.
// Packing: per byte, the low then the high value pass through the shared multiplier; the next byte waits
// until the byte is done and the output is free, and no input is taken until the last byte is done.
// Reset clears control, maximum and the non-finite flag; the value store is left undefined, no clear pass.
module q4_block_quantize_core import q4bq_pkg::*; #(
	parameter int BLOCK_VALUES = BLOCK_VALUES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	q4bq_stream_if.sink     din,
	q4bq_stream_if.source   dout
);
	localparam int AW = $clog2(BLOCK_VALUES);

	cmd_t          cmd;
	status_t       status;
	out_item_t     result;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          in_ready;
	logic          out_valid;

	q4bq_ctrl #(
		.BLOCK_VALUES(BLOCK_VALUES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (in_ready),
		.out_ready(dout.ready),
		.out_valid(out_valid),
		.status   (status),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	q4bq_dpath #(
		.BLOCK_VALUES(BLOCK_VALUES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.value_bits(din.payload.value_bits),
		.status    (status),
		.result    (result)
	);

	assign din.ready    = in_ready;
	assign dout.valid   = out_valid;
	assign dout.payload = result;
endmodule

### tb/tb.sv
// Self-checking testbench of the 4-bit block quantizer: predicts packed bytes per block.
module tb;
	import q4bq_pkg::*;

	localparam int NVAL = BLOCK_VALUES_DEF;
	localparam int NBYTE = NVAL / 2;
	localparam logic [31:0] SINGLE_INF = 32'h7f800000;

	// Scoreboard: holds the block being filled and the bytes it is expected to produce
	class q4_scoreboard;
		out_item_t   pending[$];
		logic [31:0] held[NVAL];
		int          fill;
		logic [31:0] peak;
		bit          nonfinite;
		int          errors;

		function new();
			clear_block();
			errors = 0;
		endfunction

		function void clear_block();
			fill = 0;
			peak = MAX_FLOOR;
			nonfinite = 0;
		endfunction

		// Exact value of a finite single bit pattern
		function real single_value(logic [31:0] b);
			logic [63:0] d;
			real r;
			if (b[30:23] == 8'd0) begin
				r = real'(b[22:0]) * (2.0 ** (-149));
				return b[31] ? -r : r;
			end
			d = {b[31], 11'(b[30:23] - 127 + 1023), b[22:0], 29'd0};
			return $bitstoreal(d);
		endfunction

		// Round a double to single precision, nearest even; tiny and huge values pass through
		function real round_single(real x);
			logic [63:0] b;
			logic [63:0] keep;
			logic [28:0] low;
			b = $realtobits(x);
			if (b[62:52] < 11'd897 || b[62:52] > 11'd1150)
				return x;
			keep = b >> 29;
			low = b[28:0];
			if (low > 29'h10000000 || (low == 29'h10000000 && keep[0]))
				keep = keep + 1;
			return $bitstoreal(keep << 29);
		endfunction

		// Single to half: half up on the first dropped bit, overflow to infinity
		function logic [15:0] half_of(logic [31:0] b);
			logic [15:0] sgn;
			int e;
			logic [31:0] m;
			logic [31:0] r;
			int sh;
			sgn = {b[31], 15'd0};
			e = int'(b[30:23]) - 127 + 15;
			m = {9'd0, b[22:0]};
			if (e <= 0) begin
				if (e < -10)
					return sgn;
				m = m | 32'h800000;
				sh = 14 - e;
				r = m >> sh;
				if ((m >> (sh - 1)) & 1)
					r = r + 1;
				return sgn | r[15:0];
			end
			if (e >= 31)
				return sgn | 16'(HALF_INF);
			r = m >> 13;
			if (m & 32'h1000) begin
				r = r + 1;
				if (r == 32'h400) begin
					r = 0;
					e = e + 1;
					if (e >= 31)
						return sgn | 16'(HALF_INF);
				end
			end
			return sgn | 16'(e << 10) | r[15:0];
		endfunction

		// Round half to even and clamp to [-8,7]
		function int quant4(real p);
			int t;
			real fr;
			if (p >= 8.0)
				return 7;
			if (p <= -9.0)
				return -8;
			t = $rtoi(p);
			fr = p - real'(t);
			if (fr > 0.5 || (fr == 0.5 && (t % 2) != 0))
				t++;
			else if (fr < -0.5 || (fr == -0.5 && (t % 2) != 0))
				t--;
			if (t > 7)
				t = 7;
			if (t < -8)
				t = -8;
			return t;
		endfunction

		function int code_of(logic [31:0] v, real inv);
			if (v[30:23] == 8'hff)
				return -8;
			if (peak == SINGLE_INF)
				return 0;
			return quant4(round_single(single_value(v) * inv));
		endfunction

		// Note an accepted value; on the last of a block, queue its bytes
		function void note_value(logic [31:0] v);
			logic [31:0] mag;
			logic [31:0] scale_bits;
			real inv;
			out_item_t item;
			int lo;
			int hi;
			mag = v & 32'h7fffffff;
			if (v[30:23] == 8'hff)
				nonfinite = 1;
			if (!(v[30:23] == 8'hff && v[22:0] != 0) && mag > peak)
				peak = mag;
			held[fill] = v;
			fill++;
			if (fill < NVAL)
				return;
			// max is at least the floor, so dividing by 8 only lowers the exponent
			scale_bits = (peak == SINGLE_INF) ? SINGLE_INF : peak - (32'd3 << 23);
			inv = (peak == SINGLE_INF) ? 0.0 : round_single(1.0 / single_value(scale_bits));
			for (int l = 0; l < NBYTE; l++) begin
				lo = code_of(held[l], inv) + 8;
				hi = code_of(held[l + NBYTE], inv) + 8;
				item.scale_half = half_of(scale_bits);
				item.packed_byte = {4'(hi), 4'(lo)};
				item.byte_index = 4'(l);
				item.last_byte = (l == NBYTE - 1);
				item.bad_input = nonfinite;
				pending.push_back(item);
			end
			clear_block();
		endfunction

		// Compare one output transaction with the oldest expected byte
		function void check_byte(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$error("unexpected output transaction %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.scale_half !== want.scale_half) begin
				$error("scale_half expected %h got %h", want.scale_half, got.scale_half);
				errors++;
			end
			if (got.packed_byte !== want.packed_byte) begin
				$error("packed_byte expected %h got %h", want.packed_byte, got.packed_byte);
				errors++;
			end
			if (got.byte_index !== want.byte_index) begin
				$error("byte_index expected %0d got %0d", want.byte_index, got.byte_index);
				errors++;
			end
			if (got.last_byte !== want.last_byte) begin
				$error("last_byte expected %b got %b", want.last_byte, got.last_byte);
				errors++;
			end
			if (got.bad_input !== want.bad_input) begin
				$error("bad_input expected %b got %b", want.bad_input, got.bad_input);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle;

	q4bq_stream_if #(.payload_t(in_item_t))  din_if();
	q4bq_stream_if #(.payload_t(out_item_t)) dout_if();

	q4_block_quantize_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_if.sink),
		.dout(dout_if.source)
	);

	q4_scoreboard quant_sb = new();

	// Clock and cycle count
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycle <= cycle + 1;

	// Hold reset, then release it
	initial begin
		cycle = 0;
		arst_n <= 0;
		din_if.valid <= 0;
		din_if.payload <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	// Stall the output on a pattern, with one long hold-off
	int hold_left = 0;
	int ready_phase = 0;
	initial begin
		dout_if.ready <= 0;
		forever begin
			@(posedge clk);
			if (cycle == 1200)
				hold_left = 400;
			if (hold_left > 0) begin
				hold_left--;
				dout_if.ready <= 0;
			end else begin
				ready_phase = (ready_phase + 1) % 300;
				if (ready_phase < 80)
					dout_if.ready <= 1;
				else
					dout_if.ready <= ($urandom_range(0, 99) < 60);
			end
		end
	end

	// Check accepted output transactions at mid-cycle
	always @(negedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready)
			quant_sb.check_byte(dout_if.payload);
	end

	// Offer one value and hold it until accepted
	task automatic push_value(logic [31:0] v);
		bit taken;
		din_if.valid <= 1;
		din_if.payload.value_bits <= v;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = din_if.ready;
			@(posedge clk);
		end
		quant_sb.note_value(v);
	endtask

	task automatic idle_input(int n);
		din_if.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	// Hold the input until every expected byte has left
	task automatic drain_output();
		while (quant_sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Mostly values of similar scale, some raw patterns and zeros
	function automatic logic [31:0] random_value(int base_exp);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return $urandom;
		if (pick < 13)
			return {1'($urandom), 31'd0};
		return {1'($urandom), 8'($urandom_range(base_exp - 6, base_exp + 2)), 23'($urandom)};
	endfunction

	logic [31:0] directed_vals[NVAL] = '{
		32'h41000000, 32'h3f000000, 32'h3fc00000, 32'h40200000, 32'hbf000000, 32'hc0200000,
		32'h40f00000, 32'hc1080000, 32'hc1100000, 32'h00000001, 32'h80000000, 32'h00000000,
		32'h3f800000, 32'hbf800000, 32'h40e00000, 32'hc1000000, 32'h40d00000, 32'hc0d00000,
		32'h40b00000, 32'hc0b00000, 32'h3e800000, 32'h3f400000, 32'h007fffff, 32'h358637bd,
		32'h40900000, 32'h40600000, 32'h3fe00000, 32'hbfe00000, 32'h40400000, 32'hc0400000,
		32'h3f7fffff, 32'hbf7fffff
	};

	initial begin
		int burst;
		int base_exp;
		@(posedge arst_n);
		@(posedge clk);
		// directed: rounding and saturation at a block scale of 1.125
		foreach (directed_vals[i])
			push_value(directed_vals[i]);
		idle_input(1);
		drain_output();
		// directed: largest finite, NaN and infinity in separate blocks, then zeros and the smallest subnormal
		for (int i = 0; i < NVAL; i++)
			push_value(i == 0 ? 32'h7f7fffff : (i == 1 ? 32'hff7fffff : random_value(250)));
		for (int i = 0; i < NVAL; i++)
			push_value(i == 3 ? 32'h7fc00001 : (i == 20 ? 32'hffffffff : random_value(127)));
		for (int i = 0; i < NVAL; i++)
			push_value(i == 5 ? 32'hff800000 : random_value(127));
		for (int i = 0; i < NVAL; i++)
			push_value(32'(i & 1));
		idle_input(1);
		drain_output();
		// random blocks in bursts with gaps
		for (int blk = 0; blk < 6; blk++) begin
			base_exp = (blk % 4 == 0) ? $urandom_range(8, 245) : $urandom_range(110, 140);
			burst = 0;
			for (int i = 0; i < NVAL; i++) begin
				if (burst == 0) begin
					burst = $urandom_range(1, 20);
					if ($urandom_range(0, 2) != 0)
						idle_input($urandom_range(1, 12));
				end
				push_value(random_value(base_exp));
				burst--;
			end
		end
		din_if.valid <= 0;
		drain_output();
		repeat (200) @(posedge clk);
		if (quant_sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Run limit
	initial begin
		#2000000;
		$display("tb: errors");
		$finish;
	end
endmodule
